/* design/barometric_pressure_compensation_defines.svh */
// ----------------------------------------------------------------------------
// barometric pressure compensation assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types, constants and helpers of the pressure compensation pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int DIV_W     = 32;
    localparam int DIV_STEPS = DIV_W;

    localparam logic [31:0] T_OFFSET   = 32'd4000;
    localparam logic [31:0] B4_OFFSET  = 32'd32768;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] K_SQ       = 32'd3038;
    localparam logic [31:0] K_LIN      = 32'hFFFF_E343; // -7357
    localparam logic [31:0] K_OFFSET   = 32'd3791;

    typedef enum logic [1:0] {
        REG_CAL_A = 2'd0,
        REG_CAL_B = 2'd1,
        REG_CAL_C = 2'd2,
        REG_OSS   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic err;
    } bpc_ctl_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] s);
        return 32'($signed(x) >>> s);
    endfunction

endpackage

`default_nettype wire

/* design/bpc_div.sv */
// ----------------------------------------------------------------------------
// bpc_div
// unsigned restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [bpc_pkg::DIV_W-1:0] dividend,
    input  wire logic [bpc_pkg::DIV_W-1:0] divisor,
    output logic      [bpc_pkg::DIV_W-1:0] quotient
);

    logic [bpc_pkg::DIV_W-1:0] rem_reg [bpc_pkg::DIV_STEPS];
    logic [bpc_pkg::DIV_W-1:0] qd_reg  [bpc_pkg::DIV_STEPS];
    logic [bpc_pkg::DIV_W-1:0] dvs_reg [bpc_pkg::DIV_STEPS];

    for (genvar s = 0; s < bpc_pkg::DIV_STEPS; s++) begin : g_step
        logic [bpc_pkg::DIV_W-1:0] rem_in;
        logic [bpc_pkg::DIV_W-1:0] qd_in;
        logic [bpc_pkg::DIV_W-1:0] dvs_in;
        logic [bpc_pkg::DIV_W:0]   trial;
        logic                      ge;
        logic [bpc_pkg::DIV_W-1:0] rem_next;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign qd_in  = dividend;
            assign dvs_in = divisor;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign qd_in  = qd_reg[s-1];
            assign dvs_in = dvs_reg[s-1];
        end

        // dividend bits shift out the top as quotient bits shift in
        assign trial    = {rem_in, qd_in[bpc_pkg::DIV_W-1]};
        assign ge       = trial >= {1'b0, dvs_in};
        assign rem_next = ge ? bpc_pkg::DIV_W'(trial - {1'b0, dvs_in})
                             : trial[bpc_pkg::DIV_W-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                qd_reg[s]  <= {qd_in[bpc_pkg::DIV_W-2:0], ge};
                dvs_reg[s] <= dvs_in;
            end
        end
    end

    assign quotient = qd_reg[bpc_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

/* design/bpc_corr.sv */
// ----------------------------------------------------------------------------
// bpc_corr
// second-order pressure correction, three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_corr (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire bpc_pkg::bpc_ctl_t in_ctl,
    input  wire logic [31:0]       p,
    output bpc_pkg::bpc_ctl_t      out_ctl,
    output logic [31:0]            pressure
);

    bpc_pkg::bpc_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    logic [31:0] p1_reg, sq_reg, lin1_reg;
    logic [31:0] p2_reg, m2_reg, lin2_reg;
    logic [31:0] out_reg;

    logic [31:0] x1_next;
    logic [31:0] out_next;

    assign x1_next  = bpc_pkg::asr(p, 5'd8);
    assign out_next = p2_reg + bpc_pkg::asr(bpc_pkg::asr(m2_reg, 5'd16)
                      + bpc_pkg::asr(lin2_reg, 5'd16) + bpc_pkg::K_OFFSET, 5'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= p;
            sq_reg   <= x1_next * x1_next;
            lin1_reg <= bpc_pkg::K_LIN * p;
            p2_reg   <= p1_reg;
            m2_reg   <= sq_reg * bpc_pkg::K_SQ;
            lin2_reg <= lin1_reg;
            // a zero divisor anywhere forces the word to zero
            out_reg  <= ctl2_reg.err ? '0 : out_next;
        end
    end

    assign out_ctl  = ctl3_reg;
    assign pressure = out_reg;

endmodule

`default_nettype wire

/* design/barometric_pressure_compensation.sv */
// path: stages a-d, temperature divider, stages e-m, pressure divider, stage n, correction
// throughput: one word per cycle; the whole pipeline holds while a result waits
// the two 32-stage dividers set most of the latency, one quotient bit a stage
// reset: pipeline valid bits clear, calibration words clear, oversampling mode 3
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// pipelined integer calibration chain from raw readings to pascals
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] raw_temperature,
    input  wire logic [15:0] raw_pressure_word,
    input  wire logic [7:0]  raw_pressure_extra,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] pressure_pa,
    output logic             divide_error
);

    logic [63:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;

    logic adv;
    bpc_pkg::bpc_ctl_t corr_ctl;
    logic [31:0] corr_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= 2'd3;
        end
        else if (cfg_valid)
        begin
            case (bpc_pkg::cfg_reg_t'(cfg_index))
                bpc_pkg::REG_CAL_A: cal_a_reg <= cfg_data;
                bpc_pkg::REG_CAL_B: cal_b_reg <= cfg_data;
                bpc_pkg::REG_CAL_C: cal_c_reg <= cfg_data[31:0];
                bpc_pkg::REG_OSS:   oss_reg   <= cfg_data[1:0];
                default:            oss_reg   <= oss_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, mc, md;
    assign ac1 = bpc_pkg::sx16(cal_a_reg[15:0]);
    assign ac2 = bpc_pkg::sx16(cal_a_reg[31:16]);
    assign ac3 = bpc_pkg::sx16(cal_a_reg[47:32]);
    assign ac4 = {16'd0, cal_a_reg[63:48]};
    assign ac5 = {16'd0, cal_b_reg[15:0]};
    assign ac6 = {16'd0, cal_b_reg[31:16]};
    assign cb1 = bpc_pkg::sx16(cal_b_reg[47:32]);
    assign cb2 = bpc_pkg::sx16(cal_b_reg[63:48]);
    assign mc  = bpc_pkg::sx16(cal_c_reg[15:0]);
    assign md  = bpc_pkg::sx16(cal_c_reg[31:16]);

    assign adv      = !corr_ctl.valid || out_ready;
    assign in_ready = adv;

    // valid bits of the stages outside the dividers
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, g_v_reg;
    logic h_v_reg, i_v_reg, j_v_reg, k_v_reg, l_v_reg, m_v_reg, n_v_reg;
    logic q1_v_reg [bpc_pkg::DIV_STEPS];
    logic q2_v_reg [bpc_pkg::DIV_STEPS];

    // payload
    logic [15:0] a_ut_reg;
    logic [23:0] a_up_reg, b_up_reg, c_up_reg, d_up_reg, e_up_reg, f_up_reg;
    logic [23:0] g_up_reg, h_up_reg, i_up_reg, j_up_reg;
    logic [31:0] b_prod_reg;
    logic [31:0] c_x1_reg, c_den_reg;
    logic [31:0] d_x1_reg, d_nmag_reg, d_dmag_reg;
    logic        d_neg_reg, d_err_reg;
    logic [31:0] q1_x1_reg  [bpc_pkg::DIV_STEPS];
    logic [23:0] q1_up_reg  [bpc_pkg::DIV_STEPS];
    logic        q1_neg_reg [bpc_pkg::DIV_STEPS];
    logic        q1_err_reg [bpc_pkg::DIV_STEPS];
    logic [31:0] e_b6_reg;
    logic        e_err_reg, f_err_reg, g_err_reg, h_err_reg, i_err_reg, j_err_reg;
    logic        k_err_reg, l_err_reg, m_err_reg, n_err_reg;
    logic [31:0] f_sq_reg, f_m2_reg, f_m3_reg;
    logic [31:0] g_sq_reg, g_x2a_reg, g_x1b_reg;
    logic [31:0] h_p2_reg, h_p1_reg, h_x2a_reg, h_x1b_reg;
    logic [31:0] i_t_reg, i_x3b_reg;
    logic [31:0] j_b3_reg, j_b4p_reg;
    logic [31:0] k_b4_reg, k_diff_reg;
    logic [31:0] l_b7_reg, l_dvs_reg;
    logic [31:0] m_dvd_reg, m_dvs_reg;
    logic        m_post2_reg;
    logic        q2_post2_reg [bpc_pkg::DIV_STEPS];
    logic        q2_err_reg   [bpc_pkg::DIV_STEPS];
    logic [31:0] n_p_reg;

    logic [31:0] div1_q, div2_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
            l_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            n_v_reg <= 1'b0;
            for (int s = 0; s < bpc_pkg::DIV_STEPS; s++)
            begin
                q1_v_reg[s] <= 1'b0;
                q2_v_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            q1_v_reg[0] <= d_v_reg;
            q2_v_reg[0] <= m_v_reg;
            for (int s = 1; s < bpc_pkg::DIV_STEPS; s++)
            begin
                q1_v_reg[s] <= q1_v_reg[s-1];
                q2_v_reg[s] <= q2_v_reg[s-1];
            end
            e_v_reg <= q1_v_reg[bpc_pkg::DIV_STEPS-1];
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
            j_v_reg <= i_v_reg;
            k_v_reg <= j_v_reg;
            l_v_reg <= k_v_reg;
            m_v_reg <= l_v_reg;
            n_v_reg <= q2_v_reg[bpc_pkg::DIV_STEPS-1];
        end
    end

    // combinational pieces between stages
    logic [3:0]  up_shift;
    logic [31:0] ut_diff, c_x1_next, c_den_next, num, q1_signed, e_b6_next;
    logic [31:0] i_x3, i_t_next, i_x3b_next, j_b3_next, k_b4_next;
    logic [31:0] b7_scale;

    assign up_shift   = 4'd8 - {2'd0, oss_reg};
    assign ut_diff    = {16'd0, a_ut_reg} - ac6;
    assign c_x1_next  = bpc_pkg::asr(b_prod_reg, 5'd15);
    assign c_den_next = c_x1_next + md;
    assign num        = mc << 11;
    assign q1_signed  = q1_neg_reg[bpc_pkg::DIV_STEPS-1] ? 32'(-div1_q) : div1_q;
    assign e_b6_next  = q1_x1_reg[bpc_pkg::DIV_STEPS-1] + q1_signed - bpc_pkg::T_OFFSET;
    assign i_x3       = bpc_pkg::asr(h_p2_reg, 5'd11) + h_x2a_reg;
    assign i_t_next   = (((ac1 << 2) + i_x3) << oss_reg) + 32'd2;
    assign i_x3b_next = bpc_pkg::asr(h_x1b_reg + bpc_pkg::asr(h_p1_reg, 5'd16) + 32'd2, 5'd2);
    // truncating division by four
    assign j_b3_next  = bpc_pkg::asr(i_t_reg + (i_t_reg[31] ? 32'd3 : 32'd0), 5'd2);
    assign k_b4_next  = j_b4p_reg >> 15;
    assign b7_scale   = bpc_pkg::B7_SCALE >> oss_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ut_reg   <= raw_temperature;
            a_up_reg   <= {raw_pressure_word, raw_pressure_extra} >> up_shift;

            b_prod_reg <= ut_diff * ac5;
            b_up_reg   <= a_up_reg;

            c_x1_reg   <= c_x1_next;
            c_den_reg  <= c_den_next;
            c_up_reg   <= b_up_reg;

            d_x1_reg   <= c_x1_reg;
            d_up_reg   <= c_up_reg;
            d_nmag_reg <= num[31] ? 32'(-num) : num;
            d_dmag_reg <= (c_den_reg == '0) ? 32'd1
                        : (c_den_reg[31] ? 32'(-c_den_reg) : c_den_reg);
            d_neg_reg  <= num[31] ^ c_den_reg[31];
            d_err_reg  <= c_den_reg == '0;

            q1_x1_reg[0]  <= d_x1_reg;
            q1_up_reg[0]  <= d_up_reg;
            q1_neg_reg[0] <= d_neg_reg;
            q1_err_reg[0] <= d_err_reg;
            q2_post2_reg[0] <= m_post2_reg;
            q2_err_reg[0]   <= m_err_reg;
            for (int s = 1; s < bpc_pkg::DIV_STEPS; s++)
            begin
                q1_x1_reg[s]    <= q1_x1_reg[s-1];
                q1_up_reg[s]    <= q1_up_reg[s-1];
                q1_neg_reg[s]   <= q1_neg_reg[s-1];
                q1_err_reg[s]   <= q1_err_reg[s-1];
                q2_post2_reg[s] <= q2_post2_reg[s-1];
                q2_err_reg[s]   <= q2_err_reg[s-1];
            end

            e_b6_reg  <= e_b6_next;
            e_up_reg  <= q1_up_reg[bpc_pkg::DIV_STEPS-1];
            e_err_reg <= q1_err_reg[bpc_pkg::DIV_STEPS-1];

            f_sq_reg  <= e_b6_reg * e_b6_reg;
            f_m2_reg  <= ac2 * e_b6_reg;
            f_m3_reg  <= ac3 * e_b6_reg;
            f_up_reg  <= e_up_reg;
            f_err_reg <= e_err_reg;

            g_sq_reg  <= bpc_pkg::asr(f_sq_reg, 5'd12);
            g_x2a_reg <= bpc_pkg::asr(f_m2_reg, 5'd11);
            g_x1b_reg <= bpc_pkg::asr(f_m3_reg, 5'd13);
            g_up_reg  <= f_up_reg;
            g_err_reg <= f_err_reg;

            h_p2_reg  <= cb2 * g_sq_reg;
            h_p1_reg  <= cb1 * g_sq_reg;
            h_x2a_reg <= g_x2a_reg;
            h_x1b_reg <= g_x1b_reg;
            h_up_reg  <= g_up_reg;
            h_err_reg <= g_err_reg;

            i_t_reg   <= i_t_next;
            i_x3b_reg <= i_x3b_next;
            i_up_reg  <= h_up_reg;
            i_err_reg <= h_err_reg;

            j_b3_reg  <= j_b3_next;
            j_b4p_reg <= ac4 * (i_x3b_reg + bpc_pkg::B4_OFFSET);
            j_up_reg  <= i_up_reg;
            j_err_reg <= i_err_reg;

            k_b4_reg   <= k_b4_next;
            k_diff_reg <= {8'd0, j_up_reg} - j_b3_reg;
            k_err_reg  <= j_err_reg || (k_b4_next == '0);

            l_b7_reg  <= k_diff_reg * b7_scale;
            l_dvs_reg <= (k_b4_reg == '0) ? 32'd1 : k_b4_reg;
            l_err_reg <= k_err_reg;

            // large b7 divides first and doubles after
            m_dvd_reg   <= l_b7_reg[31] ? l_b7_reg : (l_b7_reg << 1);
            m_dvs_reg   <= l_dvs_reg;
            m_post2_reg <= l_b7_reg[31];
            m_err_reg   <= l_err_reg;

            n_p_reg   <= q2_post2_reg[bpc_pkg::DIV_STEPS-1] ? (div2_q << 1) : div2_q;
            n_err_reg <= q2_err_reg[bpc_pkg::DIV_STEPS-1];
        end
    end

    bpc_div u_div_temp (
        .clk      (clk),
        .en       (adv),
        .dividend (d_nmag_reg),
        .divisor  (d_dmag_reg),
        .quotient (div1_q)
    );

    bpc_div u_div_press (
        .clk      (clk),
        .en       (adv),
        .dividend (m_dvd_reg),
        .divisor  (m_dvs_reg),
        .quotient (div2_q)
    );

    bpc_corr u_corr (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_ctl   ('{valid: n_v_reg, err: n_err_reg}),
        .p        (n_p_reg),
        .out_ctl  (corr_ctl),
        .pressure (corr_p)
    );

    assign out_valid    = corr_ctl.valid;
    assign divide_error = corr_ctl.err;
    assign pressure_pa  = $signed(corr_p);

endmodule

`default_nettype wire

/* design/bpc_checker.sv */
// ----------------------------------------------------------------------------
// bpc_checker
// port-level checks of the pressure compensation block, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "barometric_pressure_compensation_defines.svh"

module bpc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_ready,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] pressure_pa,
    input wire logic        divide_error
);

    `BPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pressure_pa), "result word changed while stalled")
    `BPC_ASSERT_NOW(a_err_zero, out_valid && divide_error, pressure_pa == 32'd0, "divide error with nonzero pressure")
    `BPC_ASSERT_NOW(a_ready_idle, !out_valid, in_ready, "input stalled with empty output")
    `BPC_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "config port not ready")

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pressure_pa  (pressure_pa),
    .divide_error (divide_error)
);

`default_nettype wire
